/* design/ufb_pkg.sv */
// Shared types and constants for the UDP/IPv4/Ethernet frame builder.
// No dependencies; imported by every module of the block.
package ufb_pkg;

	localparam logic [10:0] MAX_PAYLOAD = 11'd1400;
	localparam int          LEN_W       = 11;
	localparam logic [5:0]  HDR_BYTES   = 6'd42;
	localparam int          IDX_W       = 6;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0]  BCAST_BYTE   = 8'hFF;
	localparam logic [7:0]  ETYPE_HI     = 8'h08;
	localparam logic [7:0]  IP_VER_IHL   = 8'h45;
	localparam logic [7:0]  IP_TTL       = 8'h40;
	localparam logic [7:0]  IP_PROTO_UDP = 8'h11;
	localparam logic [15:0] IP_TOT_BASE  = 16'd28;
	localparam logic [15:0] UDP_LEN_BASE = 16'd8;
	localparam logic [15:0] CSUM_FIXED   = {IP_VER_IHL, 8'h00} + {IP_TTL, IP_PROTO_UDP};

	localparam logic [15:0] SRC_PORT_RST  = 16'h0000;
	localparam logic [31:0] SOURCE_IP_RST = 32'h0A00020F;

	localparam logic REG_SRC_PORT  = 1'b0;
	localparam logic REG_SOURCE_IP = 1'b1;

	typedef enum logic [2:0] {
		CMD_HDR  = 3'b001,
		CMD_DATA = 3'b010,
		CMD_REJ  = 3'b100
	} cmd_kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'b001,
		MODE_ACTIVE = 3'b010,
		MODE_DROP   = 3'b100
	} mode_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic             last;
		logic [7:0]       data;
		logic [31:0]      dst_ip;
		logic [15:0]      dest_port;
		logic [LEN_W-1:0] len;
	} cmd_t;

endpackage

/* design/ufb_front.sv */
// Input side: accepts items, tracks packet mode and bytes left, issues commands.
// Depends on ufb_pkg.
module ufb_front import ufb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             first_of_packet,
	input  logic [31:0]      dst_ip,
	input  logic [15:0]      dest_port,
	input  logic [LEN_W-1:0] payload_len,
	input  logic [7:0]       data_byte,
	input  logic             q_full,
	output logic             push,
	output cmd_t             push_cmd
);

	mode_t            mode_q, mode_d;
	logic [LEN_W-1:0] left_q, left_d;
	logic             accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		mode_d             = mode_q;
		left_d             = left_q;
		push               = 1'b0;
		push_cmd.kind      = CMD_DATA;
		push_cmd.last      = 1'b0;
		push_cmd.data      = data_byte;
		push_cmd.dst_ip    = dst_ip;
		push_cmd.dest_port = dest_port;
		push_cmd.len       = payload_len;
		if (accept) begin
			if (first_of_packet) begin
				push = 1'b1;
				if (payload_len == '0 || payload_len > MAX_PAYLOAD) begin
					push_cmd.kind = CMD_REJ;
					push_cmd.last = 1'b1;
					mode_d        = MODE_DROP;
					left_d        = '0;
				end else begin
					push_cmd.kind = CMD_HDR;
					push_cmd.last = (payload_len == LEN_W'(1));
					left_d        = payload_len - LEN_W'(1);
					mode_d        = (payload_len == LEN_W'(1)) ? MODE_IDLE : MODE_ACTIVE;
				end
			end else if (mode_q == MODE_ACTIVE && left_q != '0) begin
				push          = 1'b1;
				push_cmd.last = (left_q == LEN_W'(1));
				left_d        = left_q - LEN_W'(1);
				if (left_q == LEN_W'(1)) begin
					mode_d = MODE_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			left_q <= '0;
		end else begin
			mode_q <= mode_d;
			left_q <= left_d;
		end
	end

`ifndef SYNTHESIS
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != MODE_ACTIVE |-> left_q == '0)
		else $error("bytes left outside an active packet");
	a_active_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_ACTIVE |-> left_q != '0)
		else $error("active packet with no bytes left");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("command issued into a full queue");
`endif

endmodule

/* design/ufb_queue.sv */
// Command queue between the front and back sides, flop storage.
// Depends on ufb_pkg.
module ufb_queue import ufb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head
);

	cmd_t              mem [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count overflow");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0 && cnt_q != QCNT_W'(QDEPTH)) |-> wr_q != rd_q)
		else $error("queue pointers disagree with count");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");
`endif

endmodule

/* design/ufb_back.sv */
// Output side: expands queued commands into frame bytes, computes the IPv4 checksum.
// Depends on ufb_pkg.
module ufb_back import ufb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  cmd_t        head,
	output logic        pop,
	input  logic [15:0] src_port,
	input  logic [31:0] source_ip,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_byte,
	output logic        frame_last,
	output logic        rejected
);

	logic [IDX_W-1:0] idx_q;
	logic [18:0]      acc_q;
	logic             out_valid_q, frame_last_q, rejected_q;
	logic [7:0]       frame_byte_q;
	logic             advance;
	logic [15:0]      tot, ulen, csum;
	logic [7:0]       hdr_byte, nxt_byte;
	logic             nxt_last, nxt_rej, cmd_done;

	assign advance = head_valid && (!out_valid_q || out_ready);
	assign tot     = 16'(head.len) + IP_TOT_BASE;
	assign ulen    = 16'(head.len) + UDP_LEN_BASE;
	assign csum    = ~acc_q[15:0];

	always_comb begin
		case (idx_q)
			6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5: hdr_byte = BCAST_BYTE;
			6'd12:   hdr_byte = ETYPE_HI;
			6'd14:   hdr_byte = IP_VER_IHL;
			6'd16:   hdr_byte = tot[15:8];
			6'd17:   hdr_byte = tot[7:0];
			6'd22:   hdr_byte = IP_TTL;
			6'd23:   hdr_byte = IP_PROTO_UDP;
			6'd24:   hdr_byte = csum[15:8];
			6'd25:   hdr_byte = csum[7:0];
			6'd26:   hdr_byte = source_ip[31:24];
			6'd27:   hdr_byte = source_ip[23:16];
			6'd28:   hdr_byte = source_ip[15:8];
			6'd29:   hdr_byte = source_ip[7:0];
			6'd30:   hdr_byte = head.dst_ip[31:24];
			6'd31:   hdr_byte = head.dst_ip[23:16];
			6'd32:   hdr_byte = head.dst_ip[15:8];
			6'd33:   hdr_byte = head.dst_ip[7:0];
			6'd34:   hdr_byte = src_port[15:8];
			6'd35:   hdr_byte = src_port[7:0];
			6'd36:   hdr_byte = head.dest_port[15:8];
			6'd37:   hdr_byte = head.dest_port[7:0];
			6'd38:   hdr_byte = ulen[15:8];
			6'd39:   hdr_byte = ulen[7:0];
			default: hdr_byte = 8'h00;
		endcase
	end

	always_comb begin
		nxt_byte = head.data;
		nxt_last = head.last;
		nxt_rej  = 1'b0;
		cmd_done = 1'b1;
		case (head.kind)
			CMD_REJ: begin
				nxt_byte = 8'h00;
				nxt_last = 1'b1;
				nxt_rej  = 1'b1;
			end
			CMD_HDR: begin
				if (idx_q != HDR_BYTES) begin
					nxt_byte = hdr_byte;
					nxt_last = 1'b0;
					cmd_done = 1'b0;
				end
			end
			default: begin
				nxt_byte = head.data;
			end
		endcase
	end

	assign pop = advance && cmd_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				idx_q       <= cmd_done ? '0 : idx_q + IDX_W'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			frame_byte_q <= nxt_byte;
			frame_last_q <= nxt_last;
			rejected_q   <= nxt_rej;
		end
		if (advance && head.kind == CMD_HDR) begin
			case (idx_q)
				6'd0:       acc_q <= 19'(CSUM_FIXED) + 19'(tot);
				6'd1:       acc_q <= acc_q + 19'(source_ip[31:16]);
				6'd2:       acc_q <= acc_q + 19'(source_ip[15:0]);
				6'd3:       acc_q <= acc_q + 19'(head.dst_ip[31:16]);
				6'd4:       acc_q <= acc_q + 19'(head.dst_ip[15:0]);
				6'd5, 6'd6: acc_q <= 19'(acc_q[15:0]) + 19'(acc_q[18:16]);
				default:    acc_q <= acc_q;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = frame_byte_q;
	assign frame_last = frame_last_q;
	assign rejected   = rejected_q;

`ifndef SYNTHESIS
	a_rej_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rejected) |-> frame_last)
		else $error("rejection without last flag");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= HDR_BYTES)
		else $error("header index out of range");
	a_hdr_head: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != '0 |-> (head_valid && head.kind == CMD_HDR))
		else $error("header in progress without header command");
	a_csum_folded: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && idx_q == 6'd24) |-> acc_q[18:16] == 3'd0)
		else $error("checksum not folded before use");
`endif

endmodule

/* design/udp_ipv4_ethernet_frame_builder_top.sv */
// Top level of the UDP/IPv4/Ethernet frame builder: config registers and wiring.
// Depends on ufb_pkg, ufb_front, ufb_queue, ufb_back.
//
//  channel  handshake                 payload
//  in       in_valid / in_ready       first_of_packet dst_ip dest_port payload_len data_byte
//  out      out_valid / out_ready     frame_byte frame_last rejected
//  cfg      cfg_we                    cfg_index cfg_data
//
// Payload bytes pass at one per cycle while out_ready is high and no header is draining.
// A first item expands into 43 output bytes; the 4-entry command
// queue then fills and in_ready stays low until the header drains.
// A rejection and each payload byte become a single output byte.
// Reset returns both sides to idle and the registers to their defaults.
module udp_ipv4_ethernet_frame_builder_top import ufb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             first_of_packet,
	input  logic [31:0]      dst_ip,
	input  logic [15:0]      dest_port,
	input  logic [LEN_W-1:0] payload_len,
	input  logic [7:0]       data_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       frame_byte,
	output logic             frame_last,
	output logic             rejected,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [31:0]      cfg_data
);

	logic [15:0] src_port_q;
	logic [31:0] source_ip_q;
	logic        q_full, push, pop, head_valid;
	cmd_t        push_cmd, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_port_q  <= SRC_PORT_RST;
			source_ip_q <= SOURCE_IP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_PORT:  src_port_q  <= cfg_data[15:0];
				REG_SOURCE_IP: source_ip_q <= cfg_data;
				default:       src_port_q  <= src_port_q;
			endcase
		end
	end

	ufb_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.first_of_packet (first_of_packet),
		.dst_ip          (dst_ip),
		.dest_port       (dest_port),
		.payload_len     (payload_len),
		.data_byte       (data_byte),
		.q_full          (q_full),
		.push            (push),
		.push_cmd        (push_cmd)
	);

	ufb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	ufb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.src_port   (src_port_q),
		.source_ip  (source_ip_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_byte (frame_byte),
		.frame_last (frame_last),
		.rejected   (rejected)
	);

endmodule
